// File: rtl/core/qtd_pkg.sv
package qtd_pkg;

  // deepest supported tree, log2 of the largest root side
  localparam int MAX_LOG2_SIDE = 10;

  // fixed field widths
  localparam int COORD_W = 10;
  localparam int SIDE_W = 11;
  localparam int COLOR_W = 8;
  localparam int ROOT_LOG2_W = 4;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [ROOT_LOG2_W-1:0] ROOT_LOG2_RST = 4'd9;
  localparam logic [COLOR_W-1:0] GRAY_ALPHA = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_LOG2 = 4'd0,
    REG_GRAY_MODE = 4'd1
  } cfg_reg_t;

  // one input record
  typedef struct packed {
    logic               is_leaf;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIDE_W-1:0]  side;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_alpha;
    logic               tree_done;
    logic               bad_record;
  } out_item_t;

  // traversal status for the record at the head of the input register
  typedef struct packed {
    logic               emit;
    logic               bad;
    logic               done;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [SIDE_W-1:0]  side;
  } walk_stat_t;

endpackage

// File: rtl/core/qtd_walk.sv
module qtd_walk #(
  parameter int MAX_LOG2_SIDE = qtd_pkg::MAX_LOG2_SIDE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic                               step,
  input  logic                               is_leaf,
  input  logic [qtd_pkg::ROOT_LOG2_W-1:0]    root_eff,
  output qtd_pkg::walk_stat_t                stat
);

  localparam int DW = $clog2(MAX_LOG2_SIDE + 1);
  localparam int CW = MAX_LOG2_SIDE;
  localparam int SW = MAX_LOG2_SIDE + 1;
  localparam int XW = (CW > qtd_pkg::COORD_W) ? CW : qtd_pkg::COORD_W;
  localparam int ZW = (SW > qtd_pkg::SIDE_W) ? SW : qtd_pkg::SIDE_W;
  localparam int RW = qtd_pkg::ROOT_LOG2_W;

  logic [DW-1:0] depth_r, depth_nxt;
  logic [1:0]    slot_r [MAX_LOG2_SIDE];
  logic [1:0]    slot_nxt [MAX_LOG2_SIDE];
  logic [CW-1:0] cx_r, cx_nxt;
  logic [CW-1:0] cy_r, cy_nxt;
  logic          complete_r, complete_nxt;

  logic [SW-1:0] side_cur;
  logic          bad;
  logic          found;
  logic [RW-1:0] p_idx;
  logic [1:0]    p_slot;
  logic [1:0]    ns;
  logic [CW-1:0] bit_c;
  logic [CW-1:0] keep;
  logic [XW-1:0] cx_w;
  logic [XW-1:0] cy_w;
  logic [ZW-1:0] side_w;

  // side of the current square and record check
  always_comb begin
    side_cur = SW'(1) << (root_eff - RW'(depth_r));
    bad = complete_r || (!is_leaf && (RW'(depth_r) >= root_eff));
  end

  // deepest open level whose four children are not all done
  always_comb begin
    found = 1'b0;
    p_idx = '0;
    p_slot = '0;
    for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
      if ((DW'(i) < depth_r) && (slot_r[i] != 2'd3)) begin
        found = 1'b1;
        p_idx = RW'(i);
        p_slot = slot_r[i];
      end
    end
    ns = p_slot + 2'd1;
    bit_c = CW'(1) << (root_eff - RW'(1) - p_idx);
    keep = ~((bit_c << 1) - CW'(1));
  end

  // next traversal state
  always_comb begin
    depth_nxt = depth_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    complete_nxt = complete_r;
    for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (restart) begin
      depth_nxt = '0;
      cx_nxt = '0;
      cy_nxt = '0;
      complete_nxt = 1'b0;
      for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
        slot_nxt[i] = '0;
      end
    end else if (step && !bad) begin
      if (!is_leaf) begin
        // descend into the top-left quadrant
        depth_nxt = depth_r + DW'(1);
        for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
          if (DW'(i) == depth_r) begin
            slot_nxt[i] = '0;
          end
        end
      end else if (found) begin
        // pop finished levels, step to the next sibling
        depth_nxt = DW'(p_idx) + DW'(1);
        cx_nxt = (cx_r & keep) | (ns[0] ? bit_c : '0);
        cy_nxt = (cy_r & keep) | (ns[1] ? bit_c : '0);
        for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
          if (RW'(i) == p_idx) begin
            slot_nxt[i] = ns;
          end else if (RW'(i) > p_idx) begin
            slot_nxt[i] = '0;
          end
        end
      end else begin
        // last leaf of the root
        depth_nxt = '0;
        cx_nxt = '0;
        cy_nxt = '0;
        complete_nxt = 1'b1;
        for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
          slot_nxt[i] = '0;
        end
      end
    end
  end

  // traversal state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      complete_r <= 1'b0;
      for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      depth_r <= depth_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      complete_r <= complete_nxt;
      for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  // status toward the result stage
  always_comb begin
    cx_w = XW'(cx_r);
    cy_w = XW'(cy_r);
    side_w = ZW'(side_cur);
    stat.emit = is_leaf || bad;
    stat.bad = bad;
    stat.done = is_leaf && !found;
    stat.left = cx_w[qtd_pkg::COORD_W-1:0];
    stat.top = cy_w[qtd_pkg::COORD_W-1:0];
    stat.side = side_w[qtd_pkg::SIDE_W-1:0];
  end

endmodule

// File: rtl/core/qtd_pixel.sv
module qtd_pixel (
  input  qtd_pkg::in_item_t   item,
  input  logic                gray_mode,
  input  qtd_pkg::walk_stat_t stat,
  output qtd_pkg::out_item_t  result
);

  // build the result item, gray expansion and rejected-record zeroing
  always_comb begin
    result = '0;
    if (stat.bad) begin
      result.bad_record = 1'b1;
    end else begin
      result.left = stat.left;
      result.top = stat.top;
      result.side = stat.side;
      result.tree_done = stat.done;
      result.out_red = item.red;
      if (gray_mode) begin
        result.out_green = item.red;
        result.out_blue = item.red;
        result.out_alpha = qtd_pkg::GRAY_ALPHA;
      end else begin
        result.out_green = item.green;
        result.out_blue = item.blue;
        result.out_alpha = item.alpha;
      end
    end
  end

endmodule

// File: rtl/core/quadtree_preorder_decoder.sv
// Path: an accepted item is held in the input register, then its result is
// registered in the result register, where it becomes valid.
// Throughput: one item per cycle while the result side is ready; the cycle path
// is the level pop, a priority pick over the child-slot stack followed by the corner update.
// Reset: synchronous active low; root_log2 = 9, gray mode off, traversal at
// the root, both stages empty.
module quadtree_preorder_decoder #(
  parameter int MAX_LOG2_SIDE = qtd_pkg::MAX_LOG2_SIDE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qtd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qtd_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qtd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = qtd_pkg::ROOT_LOG2_W;

  logic [RW-1:0]       root_log2_r, root_log2_nxt;
  logic                gray_mode_r, gray_mode_nxt;
  logic                restart;
  logic [RW-1:0]       root_eff;

  qtd_pkg::in_item_t   in_item_r;
  logic                in_vld_r;
  qtd_pkg::out_item_t  out_item_r;
  logic                out_vld_r;

  logic                out_free;
  logic                fire;
  qtd_pkg::walk_stat_t stat;
  qtd_pkg::out_item_t  result;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    root_log2_nxt = root_log2_r;
    gray_mode_nxt = gray_mode_r;
    restart = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        qtd_pkg::REG_ROOT_LOG2: begin
          root_log2_nxt = cfg_data[RW-1:0];
          restart = 1'b1;
        end
        qtd_pkg::REG_GRAY_MODE: begin
          gray_mode_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_log2_r <= qtd_pkg::ROOT_LOG2_RST;
      gray_mode_r <= 1'b0;
    end else begin
      root_log2_r <= root_log2_nxt;
      gray_mode_r <= gray_mode_nxt;
    end
  end

  // oversized root saturates
  assign root_eff = (root_log2_r > RW'(MAX_LOG2_SIDE)) ? RW'(MAX_LOG2_SIDE) : root_log2_r;

  // handshake between the two stages
  assign out_free = !out_vld_r || out_ready;
  assign fire = in_vld_r && out_free;
  assign in_ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  qtd_walk #(
    .MAX_LOG2_SIDE(MAX_LOG2_SIDE)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .step    (fire),
    .is_leaf (in_item_r.is_leaf),
    .root_eff(root_eff),
    .stat    (stat)
  );

  qtd_pixel u_pixel (
    .item     (in_item_r),
    .gray_mode(gray_mode_r),
    .stat     (stat),
    .result   (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire && stat.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stat.emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_item_r;

  // a processed leaf or rejected record shows up as a result next cycle
  a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stat.emit |=> out_valid)
    else $error("result item lost");

  // an internal record that is accepted leaves no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !stat.emit && out_free |=> !out_valid)
    else $error("result item invented");

  // a rejected record carries no square and no completion
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_record |-> (out_data.side == '0) && !out_data.tree_done)
    else $error("rejected record with payload");

  // an accepted leaf always has a square of nonzero side
  a_side_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bad_record |-> out_data.side != '0)
    else $error("leaf with zero side");

endmodule

// File: test/tb_quadtree_preorder_decoder.sv
`timescale 1ns / 1ps

module tb_quadtree_preorder_decoder;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_CYCLES = 4;

  typedef logic [qtd_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [qtd_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [qtd_pkg::COLOR_W-1:0]    color_t;

  // no register lives at this index
  localparam cfg_idx_t REG_UNUSED = 4'd7;

  typedef enum logic {ROW_CFG, ROW_REC} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    cfg_idx_t            idx;
    cfg_data_t           data;
    qtd_pkg::in_item_t   rec;
    bit                  typed;
    qtd_pkg::out_item_t  want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  qtd_pkg::in_item_t      in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  qtd_pkg::out_item_t     out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = '0;
  cfg_data_t              cfg_data = '0;

  quadtree_preorder_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // traversal shadow state
  logic [qtd_pkg::ROOT_LOG2_W-1:0] tr_root = qtd_pkg::ROOT_LOG2_RST;
  bit                     tr_gray = 1'b0;
  int                     tr_depth = 0;
  logic [1:0]             tr_slot [qtd_pkg::MAX_LOG2_SIDE];
  int                     tr_cx = 0;
  int                     tr_cy = 0;
  bit                     tr_complete = 1'b0;

  qtd_pkg::out_item_t tile_q [$];
  dir_row_t  dir_rows [$];
  qtd_pkg::out_item_t seen_want;
  int        errors = 0;
  int        cycles = 0;
  int        good_items = 0;
  bit        no_gaps = 1'b0;

  function automatic int eff_root();
    return (tr_root > qtd_pkg::MAX_LOG2_SIDE) ? qtd_pkg::MAX_LOG2_SIDE : int'(tr_root);
  endfunction

  function automatic void restart_walk();
    tr_depth = 0;
    for (int i = 0; i < qtd_pkg::MAX_LOG2_SIDE; i++) tr_slot[i] = 2'd0;
    tr_cx = 0;
    tr_cy = 0;
    tr_complete = 1'b0;
  endfunction

  function automatic qtd_pkg::out_item_t mk_out(input int left, input int top,
                                                input int side,
                                                input color_t r, input color_t g,
                                                input color_t b, input color_t a,
                                                input bit done, input bit bad);
    qtd_pkg::out_item_t o;
    o.left = left[qtd_pkg::COORD_W-1:0];
    o.top = top[qtd_pkg::COORD_W-1:0];
    o.side = side[qtd_pkg::SIDE_W-1:0];
    o.out_red = r;
    o.out_green = g;
    o.out_blue = b;
    o.out_alpha = a;
    o.tree_done = done;
    o.bad_record = bad;
    return o;
  endfunction

  // walk one record through the tree, returns 1 when it yields a tile
  function automatic bit decode_record(input qtd_pkg::in_item_t rec,
                                       output qtd_pkg::out_item_t tile);
    int r;
    int d;
    int sd;
    int s;
    int side;
    bit moved;
    r = eff_root();
    tile = '0;
    // rejected: tree already complete or split of a single pixel
    if (tr_complete || (!rec.is_leaf && tr_depth >= r)) begin
      tile.bad_record = 1'b1;
      return 1'b1;
    end
    // internal node descends into the top-left quadrant
    if (!rec.is_leaf) begin
      tr_depth = tr_depth + 1;
      tr_slot[tr_depth-1] = 2'd0;
      return 1'b0;
    end
    side = 1 << (r - tr_depth);
    tile.left = tr_cx[qtd_pkg::COORD_W-1:0];
    tile.top = tr_cy[qtd_pkg::COORD_W-1:0];
    tile.side = side[qtd_pkg::SIDE_W-1:0];
    if (tr_gray) begin
      tile.out_red = rec.red;
      tile.out_green = rec.red;
      tile.out_blue = rec.red;
      tile.out_alpha = qtd_pkg::GRAY_ALPHA;
    end else begin
      tile.out_red = rec.red;
      tile.out_green = rec.green;
      tile.out_blue = rec.blue;
      tile.out_alpha = rec.alpha;
    end
    // step to the next sibling, popping finished levels
    moved = 1'b0;
    while (!moved && tr_depth > 0) begin
      d = tr_depth;
      sd = (d <= r) ? (1 << (r - d)) : 1;
      s = int'(tr_slot[d-1]);
      if (s < 3) begin
        tr_slot[d-1] = s[1:0] + 2'd1;
        if (s == 1) begin
          tr_cx = tr_cx - sd;
          tr_cy = tr_cy + sd;
        end else begin
          tr_cx = tr_cx + sd;
        end
        moved = 1'b1;
      end else begin
        tr_cx = tr_cx - sd;
        tr_cy = tr_cy - sd;
        tr_slot[d-1] = 2'd0;
        tr_depth = d - 1;
      end
    end
    if (!moved) begin
      tr_depth = 0;
      tr_complete = 1'b1;
    end
    tile.tree_done = tr_complete;
    return 1'b1;
  endfunction

  function automatic dir_row_t row_cfg(input cfg_idx_t idx, input cfg_data_t data);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    row.rec = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t row_rec(input bit leaf, input color_t r,
                                       input color_t g, input color_t b,
                                       input color_t a);
    dir_row_t row;
    row = row_cfg('0, '0);
    row.kind = ROW_REC;
    row.rec.is_leaf = leaf;
    row.rec.red = r;
    row.rec.green = g;
    row.rec.blue = b;
    row.rec.alpha = a;
    return row;
  endfunction

  function automatic dir_row_t row_want(input bit leaf, input color_t r,
                                        input color_t g, input color_t b,
                                        input color_t a, input qtd_pkg::out_item_t want);
    dir_row_t row;
    row = row_rec(leaf, r, g, b, a);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic string fmt_tile(input qtd_pkg::out_item_t t);
    return $sformatf("x=%0d y=%0d side=%0d rgba=%02h_%02h_%02h_%02h done=%0b bad=%0b",
                     t.left, t.top, t.side, t.out_red, t.out_green, t.out_blue,
                     t.out_alpha, t.tree_done, t.bad_record);
  endfunction

  function automatic void report_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // one item over the input channel, predicted at acceptance
  task automatic send_record(input qtd_pkg::in_item_t rec, input bit typed,
                             input qtd_pkg::out_item_t want);
    int gap;
    bit has;
    qtd_pkg::out_item_t tile;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rec;
    do @(posedge clk); while (!(in_valid && in_ready));
    has = decode_record(rec, tile);
    if (!(has && tile.bad_record)) good_items++;
    if (typed) tile_q.push_back(want);
    else if (has) tile_q.push_back(tile);
  endtask

  // register write, only once the decoder has drained
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    in_valid <= 1'b0;
    while (tile_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == qtd_pkg::REG_ROOT_LOG2) begin
      tr_root = data;
      restart_walk();
    end else if (idx == qtd_pkg::REG_GRAY_MODE) begin
      tr_gray = data[0];
    end
  endtask

  // result side back-pressure in segments
  int ready_left = 0;
  always @(posedge clk) begin
    int p;
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 50) begin
        out_ready <= 1'b1;
        ready_left <= $urandom_range(0, 19);
      end else if (p < 85) begin
        out_ready <= 1'b0;
        ready_left <= $urandom_range(0, 2);
      end else if (p < 95) begin
        out_ready <= 1'b1;
        ready_left <= $urandom_range(50, 150);
      end else begin
        out_ready <= 1'b0;
        ready_left <= $urandom_range(10, 30);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tile_q.size() == 0) begin
        report_error($sformatf("unexpected tile: %s", fmt_tile(out_data)));
      end else begin
        seen_want = tile_q.pop_front();
        if (out_data.left !== seen_want.left || out_data.top !== seen_want.top ||
            out_data.side !== seen_want.side || out_data.out_red !== seen_want.out_red ||
            out_data.out_green !== seen_want.out_green ||
            out_data.out_blue !== seen_want.out_blue ||
            out_data.out_alpha !== seen_want.out_alpha ||
            out_data.tree_done !== seen_want.tree_done ||
            out_data.bad_record !== seen_want.bad_record) begin
          report_error($sformatf("tile mismatch: expected %s got %s",
                                 fmt_tile(seen_want), fmt_tile(out_data)));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    qtd_pkg::in_item_t rec;
    qtd_pkg::out_item_t none;
    int start_items;
    int p;
    int eff;
    int split_pct;
    int abort_at;
    int sent;
    bit dive;
    bit first_child;

    none = '0;
    restart_walk();

    // directed table
    // single leaf at the reset root of 512
    dir_rows.push_back(row_want(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                mk_out(0, 0, 512, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0)));
    // record after the tree is complete
    dir_rows.push_back(row_want(1'b0, 8'h00, 8'h00, 8'h00, 8'h00,
                                mk_out(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1)));
    // one-pixel root
    dir_rows.push_back(row_cfg(qtd_pkg::REG_ROOT_LOG2, 4'd0));
    dir_rows.push_back(row_want(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                mk_out(0, 0, 1, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0)));
    // split of a single pixel is rejected, tree still open
    dir_rows.push_back(row_cfg(qtd_pkg::REG_ROOT_LOG2, 4'd0));
    dir_rows.push_back(row_want(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                mk_out(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1)));
    dir_rows.push_back(row_rec(1'b1, 8'hA5, 8'h5A, 8'h3C, 8'hC3));
    // gray mode, oversized root saturates to 1024
    dir_rows.push_back(row_cfg(qtd_pkg::REG_GRAY_MODE, 4'd1));
    dir_rows.push_back(row_cfg(qtd_pkg::REG_ROOT_LOG2, 4'd15));
    dir_rows.push_back(row_rec(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(row_rec(1'b1, 8'hFF, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(row_rec(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    dir_rows.push_back(row_rec(1'b1, 8'h7E, 8'h81, 8'h18, 8'hE7));
    dir_rows.push_back(row_rec(1'b0, 8'h12, 8'h34, 8'h56, 8'h78));
    dir_rows.push_back(row_rec(1'b1, 8'h01, 8'h80, 8'h40, 8'h20));
    dir_rows.push_back(row_rec(1'b1, 8'hFE, 8'h7F, 8'hBF, 8'hDF));
    dir_rows.push_back(row_rec(1'b1, 8'h55, 8'hAA, 8'h55, 8'hAA));
    dir_rows.push_back(row_rec(1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55));
    // unknown index ignored, back to rgba on a 2x2 root
    dir_rows.push_back(row_cfg(REG_UNUSED, 4'd5));
    dir_rows.push_back(row_cfg(qtd_pkg::REG_GRAY_MODE, 4'd0));
    dir_rows.push_back(row_cfg(qtd_pkg::REG_ROOT_LOG2, 4'd1));
    dir_rows.push_back(row_rec(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    dir_rows.push_back(row_want(1'b0, 8'h11, 8'h22, 8'h33, 8'h44,
                                mk_out(0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1)));
    dir_rows.push_back(row_rec(1'b1, 8'h10, 8'h20, 8'h30, 8'h40));
    dir_rows.push_back(row_rec(1'b1, 8'h50, 8'h60, 8'h70, 8'h80));
    dir_rows.push_back(row_rec(1'b1, 8'h90, 8'hA0, 8'hB0, 8'hC0));
    dir_rows.push_back(row_rec(1'b1, 8'hD0, 8'hE0, 8'hF0, 8'h0F));

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_record(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].want);
    end

    // random trees, one per phase
    start_items = good_items;
    while (good_items - start_items < RANDOM_ITEMS) begin
      if (tr_complete || $urandom_range(0, 99) < 80) begin
        p = $urandom_range(0, 99);
        if (p < 70) write_reg(qtd_pkg::REG_ROOT_LOG2, cfg_data_t'($urandom_range(0, 5)));
        else if (p < 90)
          write_reg(qtd_pkg::REG_ROOT_LOG2, cfg_data_t'($urandom_range(6, 10)));
        else write_reg(qtd_pkg::REG_ROOT_LOG2, cfg_data_t'($urandom_range(11, 15)));
      end
      if ($urandom_range(0, 99) < 60)
        write_reg(qtd_pkg::REG_GRAY_MODE, cfg_data_t'($urandom_range(0, 15)));
      if ($urandom_range(0, 99) < 10)
        write_reg(cfg_idx_t'($urandom_range(qtd_pkg::REG_GRAY_MODE + 1, 15)),
                  cfg_data_t'($urandom_range(0, 15)));
      dive = ($urandom_range(0, 99) < 30);
      no_gaps = ($urandom_range(0, 99) < 25);
      abort_at = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 20) : 0;
      sent = 0;

      // well-formed tree with occasional bad splits, maybe cut short
      while (!tr_complete && !(abort_at != 0 && sent >= abort_at)) begin
        eff = eff_root();
        rec.red = color_t'($urandom_range(0, 255));
        rec.green = color_t'($urandom_range(0, 255));
        rec.blue = color_t'($urandom_range(0, 255));
        rec.alpha = color_t'($urandom_range(0, 255));
        if (tr_depth >= eff) begin
          rec.is_leaf = ($urandom_range(0, 99) < 92);
        end else begin
          first_child = (tr_depth == 0) ? 1'b1 : (tr_slot[tr_depth-1] == 2'd0);
          if (dive) split_pct = first_child ? 85 : 10;
          else split_pct = (tr_depth == 0) ? 70 : 22;
          rec.is_leaf = ($urandom_range(0, 99) >= split_pct);
        end
        send_record(rec, 1'b0, none);
        sent++;
      end

      // stray records after completion
      if (tr_complete && $urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 2)) begin
          rec.is_leaf = 1'($urandom_range(0, 1));
          rec.red = color_t'($urandom_range(0, 255));
          rec.green = color_t'($urandom_range(0, 255));
          rec.blue = color_t'($urandom_range(0, 255));
          rec.alpha = color_t'($urandom_range(0, 255));
          send_record(rec, 1'b0, none);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (tile_q.size() != 0) @(posedge clk);
    repeat (2 * IDLE_CYCLES) @(posedge clk);
    if (errors == 0 && tile_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
